>>> sv/joystick_differential_drive_mixer_core_defines.svh
// assertion helpers shared by the mixer rtl
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define JDDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define JDDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/jddm_pkg.sv
`default_nettype none

package jddm_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int CFG_ADDR_BITS   = 5;
  localparam int CFG_DATA_BITS   = 32;
  localparam int BUTTON_LEVEL    = 3800;
  localparam int OUT_DEADBAND    = 4;
  localparam int CMD_LIMIT       = 100;
  localparam int DUTY_BASE       = 500;
  // 3500/99 split as 35 + 35/99, and x/99 as (x*331)>>15 for x below 3466
  localparam int DUTY_WHOLE      = 35;
  localparam int RECIP_99        = 331;
  localparam int RECIP_SHIFT     = 15;
  localparam int QUOT_BITS       = 7;

  localparam int X_CENTER_RST   = 1810;
  localparam int X_DEADBAND_RST = 60;
  localparam int X_MIN_RST      = 840;
  localparam int X_MAX_RST      = 2870;
  localparam int Y_CENTER_RST   = 1880;
  localparam int Y_DEADBAND_RST = 80;
  localparam int Y_MIN_RST      = 900;
  localparam int Y_MAX_RST      = 2920;

  localparam logic [2:0] REG_X_CENTER   = 3'd0;
  localparam logic [2:0] REG_X_DEADBAND = 3'd1;
  localparam logic [2:0] REG_X_MIN      = 3'd2;
  localparam logic [2:0] REG_X_MAX      = 3'd3;
  localparam logic [2:0] REG_Y_CENTER   = 3'd4;
  localparam logic [2:0] REG_Y_DEADBAND = 3'd5;
  localparam logic [2:0] REG_Y_MIN      = 3'd6;
  localparam logic [2:0] REG_Y_MAX      = 3'd7;

  typedef logic signed [7:0] cmd_t;

  typedef struct packed {
    logic done;
    cmd_t cmd;
  } lane_res_t;

  // clamp a mixed sum to the command range, then apply the output dead zone
  function automatic cmd_t out_band(input logic signed [8:0] s);
    cmd_t v;
    if (s > 9'(CMD_LIMIT)) begin
      v = 8'(CMD_LIMIT);
    end else if (s < -9'(CMD_LIMIT)) begin
      v = -8'(CMD_LIMIT);
    end else begin
      v = s[7:0];
    end
    if (v >= -8'(OUT_DEADBAND) && v <= 8'(OUT_DEADBAND)) begin
      v = '0;
    end
    return v;
  endfunction

  // magnitude of a nonzero command, 1..100
  function automatic logic [6:0] cmd_mag(input cmd_t c);
    cmd_t a;
    a = c[7] ? -c : c;
    return a[6:0];
  endfunction

  // 500 + ((mag-1)*3500)/99 without a divider
  function automatic logic [11:0] duty_of(input logic [6:0] mag);
    logic [6:0]  m;
    logic [11:0] t;
    logic [20:0] p;
    m = mag - 7'd1;
    t = 12'(m) * 12'(DUTY_WHOLE);
    p = 21'(t) * 21'(RECIP_99);
    return 12'(DUTY_BASE) + t + 12'(p >> RECIP_SHIFT);
  endfunction

endpackage

`default_nettype wire

>>> sv/jddm_lane.sv
`default_nettype none

`include "joystick_differential_drive_mixer_core_defines.svh"

module jddm_lane #(
  parameter int SAMPLE_BITS = jddm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [SAMPLE_BITS-1:0] raw,
  input  wire logic [SAMPLE_BITS-1:0] center,
  input  wire logic [SAMPLE_BITS-1:0] deadband,
  input  wire logic [SAMPLE_BITS-1:0] min_raw,
  input  wire logic [SAMPLE_BITS-1:0] max_raw,
  output jddm_pkg::lane_res_t         res
);
  import jddm_pkg::*;

  localparam int SW = SAMPLE_BITS + 2;
  localparam int NW = SAMPLE_BITS + QUOT_BITS;
  localparam logic [2:0] LAST_STEP = 3'd1;

  logic signed [SW-1:0] r_s, c_s, le_s, he_s, dl_s, rg_s;
  logic                 inband, pos, zero_c, sat_c;
  logic [NW-1:0]        num_c, dsh_c;

  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] div_r, div_nxt;
  logic [6:0]    q_r, q_nxt;
  logic          neg_r, neg_nxt, zero_r, zero_nxt, sat_r, sat_nxt;
  logic          busy_r, busy_nxt, fin_r, fin_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [6:0]    mag;

  // edges, side, offset and span of the active half
  always_comb begin
    r_s    = $signed({2'b00, raw});
    c_s    = $signed({2'b00, center});
    le_s   = c_s - $signed({2'b00, deadband});
    he_s   = c_s + $signed({2'b00, deadband});
    inband = (r_s >= le_s) && (r_s <= he_s);
    pos    = r_s > c_s;
    dl_s   = pos ? (r_s - he_s) : (le_s - r_s);
    rg_s   = pos ? ($signed({2'b00, max_raw}) - he_s) : (le_s - $signed({2'b00, min_raw}));
    zero_c = inband || rg_s[SW-1] || (rg_s == '0);
    num_c  = NW'(dl_s[SAMPLE_BITS-1:0]) * NW'(CMD_LIMIT);
    dsh_c  = {rg_s[SAMPLE_BITS-1:0], {QUOT_BITS{1'b0}}};
    sat_c  = num_c >= dsh_c;
  end

  always_comb begin
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    sat_nxt  = sat_r;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = 1'b0;
    if (start) begin
      rem_nxt  = num_c;
      div_nxt  = dsh_c >> 1;
      q_nxt    = '0;
      neg_nxt  = !pos;
      zero_nxt = zero_c;
      sat_nxt  = sat_c;
      busy_nxt = 1'b1;
      cnt_nxt  = 3'(QUOT_BITS);
    end else if (busy_r) begin
      // one restoring step per cycle
      if (rem_r >= div_r) begin
        rem_nxt = rem_r - div_r;
        q_nxt   = {q_r[5:0], 1'b1};
      end else begin
        q_nxt   = {q_r[5:0], 1'b0};
      end
      div_nxt = div_r >> 1;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    sat_r  <= sat_nxt;
  end

  assign mag      = (sat_r || q_r > 7'(CMD_LIMIT)) ? 7'(CMD_LIMIT) : q_r;
  assign res.done = fin_r;
  assign res.cmd  = zero_r ? '0 : (neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag}));

  `JDDM_ASSERT_NEXT(a_lane_finish, busy_r && cnt_r == LAST_STEP, fin_r && !busy_r, "lane missed its finish")
  `JDDM_ASSERT_NOW(a_lane_fin_idle, fin_r, !busy_r && !start, "lane restarted while finishing")

endmodule

`default_nettype wire

>>> sv/jddm_mix.sv
`default_nettype none

`include "joystick_differential_drive_mixer_core_defines.svh"

module jddm_mix (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire jddm_pkg::lane_res_t x_res,
  input  wire jddm_pkg::lane_res_t y_res,
  input  wire logic                button,
  input  wire logic                stall,
  output logic                     valid,
  output logic                     button_pressed,
  output jddm_pkg::cmd_t           turn_cmd,
  output jddm_pkg::cmd_t           drive_cmd,
  output jddm_pkg::cmd_t           left_cmd,
  output jddm_pkg::cmd_t           right_cmd,
  output logic                     left_enable,
  output logic                     left_forward,
  output logic [11:0]              left_duty,
  output logic                     right_enable,
  output logic                     right_forward,
  output logic [11:0]              right_duty
);
  import jddm_pkg::*;

  cmd_t held_r, held_nxt;
  cmd_t turn_c;
  logic a_v_r, a_btn_r;
  cmd_t a_turn_r, a_drive_r, a_left_r, a_right_r;
  logic valid_r, valid_nxt;
  logic btn_r, len_r, lfw_r, ren_r, rfw_r;
  cmd_t turn_r, drive_r, left_r, right_r;
  logic [11:0] ldut_r, rdut_r;

  // latched turn is used while the button is down
  assign turn_c   = button ? held_r : x_res.cmd;
  assign held_nxt = (x_res.done && !button) ? x_res.cmd : held_r;

  assign valid_nxt = a_v_r ? 1'b1 : ((valid_r && !stall) ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      a_v_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      a_v_r   <= x_res.done;
      valid_r <= valid_nxt;
    end
  end

  // mixing stage
  always_ff @(posedge clk) begin
    if (x_res.done) begin
      a_btn_r   <= button;
      a_turn_r  <= turn_c;
      a_drive_r <= y_res.cmd;
      a_left_r  <= out_band(9'(y_res.cmd) + 9'(turn_c));
      a_right_r <= out_band(9'(y_res.cmd) - 9'(turn_c));
    end
  end

  // motor stage and output word
  always_ff @(posedge clk) begin
    if (a_v_r) begin
      btn_r   <= a_btn_r;
      turn_r  <= a_turn_r;
      drive_r <= a_drive_r;
      left_r  <= a_left_r;
      right_r <= a_right_r;
      len_r   <= a_left_r != '0;
      lfw_r   <= !a_left_r[7];
      ldut_r  <= (a_left_r == '0) ? '0 : duty_of(cmd_mag(a_left_r));
      ren_r   <= a_right_r != '0;
      rfw_r   <= !a_right_r[7];
      rdut_r  <= (a_right_r == '0) ? '0 : duty_of(cmd_mag(a_right_r));
    end
  end

  assign valid          = valid_r;
  assign button_pressed = btn_r;
  assign turn_cmd       = turn_r;
  assign drive_cmd      = drive_r;
  assign left_cmd       = left_r;
  assign right_cmd      = right_r;
  assign left_enable    = len_r;
  assign left_forward   = lfw_r;
  assign left_duty      = ldut_r;
  assign right_enable   = ren_r;
  assign right_forward  = rfw_r;
  assign right_duty     = rdut_r;

  `JDDM_ASSERT_NOW(a_mix_left_en, valid_r, len_r == (left_r != '0), "left enable disagrees")
  `JDDM_ASSERT_NOW(a_mix_right_duty, valid_r && ren_r, rdut_r >= 12'(DUTY_BASE), "right duty low")

endmodule

`default_nettype wire

>>> sv/joystick_differential_drive_mixer_core.sv
// flow: an accepted sample pair runs through the 7-step quotient divider in each axis lane,
//   then the two output stages, before out_valid; in_stall holds off a new pair until
//   the output word is taken, so only one word is in flight at a time
// reset: synchronous active-low rst_n; config and control registers return to their defaults,
//   held turn clears to 0, nothing is in flight
`default_nettype none

`include "joystick_differential_drive_mixer_core_defines.svh"

module joystick_differential_drive_mixer_core #(
  parameter int SAMPLE_BITS = jddm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [jddm_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [jddm_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [jddm_pkg::CFG_DATA_BITS-1:0]      cfg_prdata,
  output logic                                   cfg_pready,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_x,
  input  wire logic [SAMPLE_BITS-1:0]            in_sample_y,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_button_pressed,
  output logic signed [7:0]                      out_turn_cmd,
  output logic signed [7:0]                      out_drive_cmd,
  output logic signed [7:0]                      out_left_cmd,
  output logic signed [7:0]                      out_right_cmd,
  output logic                                   out_left_enable,
  output logic                                   out_left_forward,
  output logic [11:0]                            out_left_duty,
  output logic                                   out_right_enable,
  output logic                                   out_right_forward,
  output logic [11:0]                            out_right_duty
);
  import jddm_pkg::*;

  logic [SAMPLE_BITS-1:0] x_center_r, x_deadband_r, x_min_r, x_max_r;
  logic [SAMPLE_BITS-1:0] y_center_r, y_deadband_r, y_min_r, y_max_r;
  logic [2:0]             reg_idx;
  logic [SAMPLE_BITS-1:0] wdata;
  logic                   cfg_wr;
  logic                   in_acc, out_acc;
  logic                   busy_r, busy_nxt;
  logic                   button_r;
  lane_res_t              x_res, y_res;

  assign reg_idx    = cfg_paddr[4:2];
  assign wdata      = cfg_pwdata[SAMPLE_BITS-1:0];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_center_r   <= SAMPLE_BITS'(X_CENTER_RST);
      x_deadband_r <= SAMPLE_BITS'(X_DEADBAND_RST);
      x_min_r      <= SAMPLE_BITS'(X_MIN_RST);
      x_max_r      <= SAMPLE_BITS'(X_MAX_RST);
      y_center_r   <= SAMPLE_BITS'(Y_CENTER_RST);
      y_deadband_r <= SAMPLE_BITS'(Y_DEADBAND_RST);
      y_min_r      <= SAMPLE_BITS'(Y_MIN_RST);
      y_max_r      <= SAMPLE_BITS'(Y_MAX_RST);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_CENTER:   x_center_r   <= wdata;
        REG_X_DEADBAND: x_deadband_r <= wdata;
        REG_X_MIN:      x_min_r      <= wdata;
        REG_X_MAX:      x_max_r      <= wdata;
        REG_Y_CENTER:   y_center_r   <= wdata;
        REG_Y_DEADBAND: y_deadband_r <= wdata;
        REG_Y_MIN:      y_min_r      <= wdata;
        REG_Y_MAX:      y_max_r      <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_CENTER:   cfg_prdata = CFG_DATA_BITS'(x_center_r);
      REG_X_DEADBAND: cfg_prdata = CFG_DATA_BITS'(x_deadband_r);
      REG_X_MIN:      cfg_prdata = CFG_DATA_BITS'(x_min_r);
      REG_X_MAX:      cfg_prdata = CFG_DATA_BITS'(x_max_r);
      REG_Y_CENTER:   cfg_prdata = CFG_DATA_BITS'(y_center_r);
      REG_Y_DEADBAND: cfg_prdata = CFG_DATA_BITS'(y_deadband_r);
      REG_Y_MIN:      cfg_prdata = CFG_DATA_BITS'(y_min_r);
      REG_Y_MAX:      cfg_prdata = CFG_DATA_BITS'(y_max_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // one word in flight, from acceptance until the result is taken
  assign in_stall = busy_r || !rst_n;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign busy_nxt = in_acc ? 1'b1 : (out_acc ? 1'b0 : busy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      button_r <= 32'(in_sample_x) >= 32'(BUTTON_LEVEL);
    end
  end

  jddm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .raw      (in_sample_x),
    .center   (x_center_r),
    .deadband (x_deadband_r),
    .min_raw  (x_min_r),
    .max_raw  (x_max_r),
    .res      (x_res)
  );

  jddm_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .raw      (in_sample_y),
    .center   (y_center_r),
    .deadband (y_deadband_r),
    .min_raw  (y_min_r),
    .max_raw  (y_max_r),
    .res      (y_res)
  );

  jddm_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .x_res          (x_res),
    .y_res          (y_res),
    .button         (button_r),
    .stall          (out_stall),
    .valid          (out_valid),
    .button_pressed (out_button_pressed),
    .turn_cmd       (out_turn_cmd),
    .drive_cmd      (out_drive_cmd),
    .left_cmd       (out_left_cmd),
    .right_cmd      (out_right_cmd),
    .left_enable    (out_left_enable),
    .left_forward   (out_left_forward),
    .left_duty      (out_left_duty),
    .right_enable   (out_right_enable),
    .right_forward  (out_right_forward),
    .right_duty     (out_right_duty)
  );

  `JDDM_ASSERT_NOW(a_lanes_aligned, 1'b1, x_res.done == y_res.done, "axis lanes out of step")
  `JDDM_ASSERT_NOW(a_out_owned, out_valid || x_res.done, busy_r, "result without a word in flight")

endmodule

`default_nettype wire

>>> dv/drive_mix_checker.sv
`timescale 1ns / 100ps

module drive_mix_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic                                cfg_pready,
  input  logic [jddm_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [jddm_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [11:0]                         in_sample_x,
  input  logic [11:0]                         in_sample_y,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_button_pressed,
  input  logic signed [7:0]                   out_turn_cmd,
  input  logic signed [7:0]                   out_drive_cmd,
  input  logic signed [7:0]                   out_left_cmd,
  input  logic signed [7:0]                   out_right_cmd,
  input  logic                                out_left_enable,
  input  logic                                out_left_forward,
  input  logic [11:0]                         out_left_duty,
  input  logic                                out_right_enable,
  input  logic                                out_right_forward,
  input  logic [11:0]                         out_right_duty,
  output int                                  fault_count,
  output int                                  pending
);
  import jddm_pkg::*;

  localparam int DUTY_SPAN  = 3500;
  localparam int DUTY_STEPS = 99;
  localparam int PRINT_CAP  = 200;

  typedef struct {
    logic        button;
    cmd_t        turn;
    cmd_t        drive;
    cmd_t        left;
    cmd_t        right;
    logic        left_en;
    logic        left_fwd;
    logic [11:0] left_duty;
    logic        right_en;
    logic        right_fwd;
    logic [11:0] right_duty;
  } drive_word_t;

  logic [11:0] axis_regs [8];
  cmd_t        latched_turn;
  drive_word_t expected_words [$];
  drive_word_t want_word;
  logic        button_now;
  int          drive_now;

  function automatic int sat_cmd(input int v);
    if (v > CMD_LIMIT) return CMD_LIMIT;
    if (v < -CMD_LIMIT) return -CMD_LIMIT;
    return v;
  endfunction

  // edges are plain ints so a centre near either end never wraps
  function automatic int axis_command(input int raw, input int ctr, input int db,
                                      input int lo, input int hi);
    int lo_edge, hi_edge, span;
    lo_edge = ctr - db;
    hi_edge = ctr + db;
    if (raw >= lo_edge && raw <= hi_edge) return 0;
    if (raw > ctr) begin
      span = hi - hi_edge;
      if (span <= 0) return 0;
      return sat_cmd(((raw - hi_edge) * CMD_LIMIT) / span);
    end
    span = lo_edge - lo;
    if (span <= 0) return 0;
    return -sat_cmd(((lo_edge - raw) * CMD_LIMIT) / span);
  endfunction

  function automatic int motor_band(input int v);
    int s;
    s = sat_cmd(v);
    if (s >= -OUT_DEADBAND && s <= OUT_DEADBAND) return 0;
    return s;
  endfunction

  function automatic void motor_drive(input int c, output logic en, output logic fwd,
                                      output logic [11:0] duty);
    int mag;
    mag  = (c < 0) ? -c : c;
    en   = (c != 0);
    fwd  = (c >= 0);
    duty = (c == 0) ? 12'd0 : 12'(DUTY_BASE + ((mag - 1) * DUTY_SPAN) / DUTY_STEPS);
  endfunction

  function automatic drive_word_t mix_drive_word(input logic button, input int turn,
                                                 input int drive);
    drive_word_t w;
    int l, r;
    l = motor_band(drive + turn);
    r = motor_band(drive - turn);
    w.button = button;
    w.turn   = cmd_t'(turn);
    w.drive  = cmd_t'(drive);
    w.left   = cmd_t'(l);
    w.right  = cmd_t'(r);
    motor_drive(l, w.left_en, w.left_fwd, w.left_duty);
    motor_drive(r, w.right_en, w.right_fwd, w.right_duty);
    return w;
  endfunction

  task automatic report_fault(input string what, input int got, input int want);
    if (fault_count < PRINT_CAP) begin
      $display("%0t: drive mix mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    fault_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_fault(what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      axis_regs[REG_X_CENTER]   = 12'(X_CENTER_RST);
      axis_regs[REG_X_DEADBAND] = 12'(X_DEADBAND_RST);
      axis_regs[REG_X_MIN]      = 12'(X_MIN_RST);
      axis_regs[REG_X_MAX]      = 12'(X_MAX_RST);
      axis_regs[REG_Y_CENTER]   = 12'(Y_CENTER_RST);
      axis_regs[REG_Y_DEADBAND] = 12'(Y_DEADBAND_RST);
      axis_regs[REG_Y_MIN]      = 12'(Y_MIN_RST);
      axis_regs[REG_Y_MAX]      = 12'(Y_MAX_RST);
      latched_turn = '0;
      expected_words.delete();
      fault_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        axis_regs[cfg_paddr[4:2]] = cfg_pwdata[11:0];
      end
      if (in_valid && !in_stall) begin
        button_now = (int'(in_sample_x) >= BUTTON_LEVEL);
        // turn only follows the stick while the button is released
        if (!button_now) begin
          latched_turn = cmd_t'(axis_command(int'(in_sample_x),
            int'(axis_regs[REG_X_CENTER]), int'(axis_regs[REG_X_DEADBAND]),
            int'(axis_regs[REG_X_MIN]), int'(axis_regs[REG_X_MAX])));
        end
        drive_now = axis_command(int'(in_sample_y),
          int'(axis_regs[REG_Y_CENTER]), int'(axis_regs[REG_Y_DEADBAND]),
          int'(axis_regs[REG_Y_MIN]), int'(axis_regs[REG_Y_MAX]));
        expected_words.push_back(mix_drive_word(button_now, int'(latched_turn), drive_now));
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_fault("word with nothing expected", 1, 0);
        end else begin
          want_word = expected_words.pop_front();
          check_field("button_pressed", out_button_pressed, want_word.button);
          check_field("turn_cmd", int'(out_turn_cmd), int'(want_word.turn));
          check_field("drive_cmd", int'(out_drive_cmd), int'(want_word.drive));
          check_field("left_cmd", int'(out_left_cmd), int'(want_word.left));
          check_field("right_cmd", int'(out_right_cmd), int'(want_word.right));
          check_field("left_enable", out_left_enable, want_word.left_en);
          check_field("left_forward", out_left_forward, want_word.left_fwd);
          check_field("left_duty", int'(out_left_duty), int'(want_word.left_duty));
          check_field("right_enable", out_right_enable, want_word.right_en);
          check_field("right_forward", out_right_forward, want_word.right_fwd);
          check_field("right_duty", int'(out_right_duty), int'(want_word.right_duty));
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

>>> dv/tb_joystick_differential_drive_mixer_core.sv
`timescale 1ns / 100ps

module tb_joystick_differential_drive_mixer_core;
  import jddm_pkg::*;

  localparam int ITEMS_PER_SET = 145;
  localparam int NUM_PHASES    = 11;
  localparam int NUM_FIXED     = 7;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_psel = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0]   cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_prdata;
  logic                       cfg_pready;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [11:0]                in_sample_x = '0;
  logic [11:0]                in_sample_y = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_button_pressed;
  logic signed [7:0]          out_turn_cmd;
  logic signed [7:0]          out_drive_cmd;
  logic signed [7:0]          out_left_cmd;
  logic signed [7:0]          out_right_cmd;
  logic                       out_left_enable;
  logic                       out_left_forward;
  logic [11:0]                out_left_duty;
  logic                       out_right_enable;
  logic                       out_right_forward;
  logic [11:0]                out_right_duty;

  int   fault_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;
  int   cur_cfg [8];

  int mode_idle [4]  = '{0, 83, 0, 22};
  int mode_stall [4] = '{0, 0, 83, 22};

  // per set: x centre, deadband, min, max, then the same for y
  int fixed_sets [NUM_FIXED][8] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095},
    '{2048, 0, 0, 4095, 2048, 0, 0, 4095},
    '{100, 300, 4095, 0, 4000, 200, 4095, 0},
    '{2000, 10, 1980, 2020, 1000, 4095, 0, 4095},
    '{0, 0, 0, 4095, 4095, 0, 0, 4095},
    '{1810, 60, 840, 2870, 1880, 80, 900, 2920}
  };

  // x, y pairs against the reset register values
  int dir_samples [19][2] = '{
    '{1810, 1880}, '{0, 0}, '{4095, 4095}, '{3799, 2920}, '{3800, 0},
    '{3900, 1880}, '{1750, 1800}, '{1870, 1960}, '{1749, 1799}, '{1871, 1961},
    '{840, 900}, '{2870, 2920}, '{1810, 2000}, '{1810, 2010}, '{1700, 2010},
    '{1810, 0}, '{1365, 2730}, '{2730, 1365}, '{1810, 4095}
  };

  joystick_differential_drive_mixer_core uut (.*);

  drive_mix_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random stall, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [11:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    // upper data bits are junk the block must drop
    cfg_pwdata  <= {20'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic load_setting(input int vals [8]);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int r = REG_X_CENTER; r <= REG_Y_MAX; r++) begin
      cfg_write(3'(r), 12'(vals[r]));
    end
  endtask

  task automatic push_sample(input int sx, input int sy);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_sample_x <= 12'(sx);
    in_sample_y <= 12'(sy);
    do @(posedge clk); while (in_stall);
  endtask

  // half the picks land near the dead zone edges and the span ends of one axis
  function automatic int pick_axis(input int ctr, input int db, input int lo, input int hi);
    int v;
    case ($urandom_range(7))
      0, 1: v = $urandom_range(4095);
      2: v = ctr - db + int'($urandom_range(6)) - 3;
      3: v = ctr + db + int'($urandom_range(6)) - 3;
      4: v = lo + int'($urandom_range(40)) - 20;
      5: v = hi + int'($urandom_range(40)) - 20;
      6: v = $urandom_range(lo, hi);
      default: v = ctr + int'($urandom_range(8)) - 4;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  function automatic void shape_axis(input int kind, output int c, output int db,
                                     output int lo, output int hi);
    if (kind == 0) begin
      c  = $urandom_range(4095);
      db = $urandom_range(4095);
      lo = $urandom_range(4095);
      hi = $urandom_range(4095);
    end else if (kind == 1) begin
      c  = $urandom_range(500, 3500);
      db = $urandom_range(200);
      lo = $urandom_range(0, c);
      hi = $urandom_range(c, 4095);
    end else begin
      c  = $urandom_range(200, 3800);
      db = $urandom_range(20);
      lo = c - db - int'($urandom_range(1, 40));
      hi = c + db + int'($urandom_range(1, 40));
    end
  endfunction

  initial begin
    int sx, sy, kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_samples[k]) push_sample(dir_samples[k][0], dir_samples[k][1]);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < NUM_FIXED) begin
        cur_cfg = fixed_sets[ph];
      end else begin
        kind = (ph < NUM_FIXED + 2) ? 0 : ph - NUM_FIXED - 1;
        shape_axis(kind, cur_cfg[REG_X_CENTER], cur_cfg[REG_X_DEADBAND],
                   cur_cfg[REG_X_MIN], cur_cfg[REG_X_MAX]);
        shape_axis(kind, cur_cfg[REG_Y_CENTER], cur_cfg[REG_Y_DEADBAND],
                   cur_cfg[REG_Y_MIN], cur_cfg[REG_Y_MAX]);
      end
      load_setting(cur_cfg);
      idle_pct  = mode_idle[ph % 4];
      stall_pct = mode_stall[ph % 4];
      if (ph == 4) hold_req <= ~hold_req;
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        if (ph == 5 && n == ITEMS_PER_SET / 2) wait_drained();
        // some runs of button presses so the latched turn gets held
        if ($urandom_range(5) == 0) begin
          sx = $urandom_range(3795, 4095);
        end else begin
          sx = pick_axis(cur_cfg[REG_X_CENTER], cur_cfg[REG_X_DEADBAND],
                         cur_cfg[REG_X_MIN], cur_cfg[REG_X_MAX]);
        end
        sy = pick_axis(cur_cfg[REG_Y_CENTER], cur_cfg[REG_Y_DEADBAND],
                       cur_cfg[REG_Y_MIN], cur_cfg[REG_Y_MAX]);
        push_sample(sx, sy);
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/jddm_pkg.sv
sv/jddm_lane.sv
sv/jddm_mix.sv
sv/joystick_differential_drive_mixer_core.sv
dv/drive_mix_checker.sv
dv/tb_joystick_differential_drive_mixer_core.sv
